// ===== rtl/sfc_pkg.sv =====
// Shared types, constants and tone-curve tables for the false-color pixel mapper.
package sfc_pkg;

  localparam int CHAN_COUNT   = 3;
  localparam int NUM_COLORS   = 3;
  localparam int CFG_PAIRS    = 3;
  localparam int CURVE_POINTS = 14;
  localparam int FRAC_W       = 14;
  localparam int Q_ONE        = 16384;
  localparam int ALPHA_W      = 15;
  localparam int DIV_STEPS    = 14;
  localparam int DIV_W        = 34;
  localparam int COEF_W       = 20;
  localparam int SEG_W        = 4;
  localparam int ENERGY_ONE   = 65536;
  localparam int ENERGY_W     = 32;
  localparam int PIX_W        = 8;
  localparam int CONTRIB_W    = 15;
  localparam int SUM_W        = 17;
  localparam int ADDR_W       = 5;

  typedef logic signed [ENERGY_W-1:0] q16_t;
  typedef logic [ALPHA_W-1:0]         q14_t;

  typedef enum logic [1:0] {
    ALPHA_ZERO,
    ALPHA_ONE,
    ALPHA_DIV
  } alpha_mode_e;

  localparam logic [1:0] COEF_A0 = 2'd0;
  localparam logic [1:0] COEF_A1 = 2'd1;
  localparam logic [1:0] COEF_A2 = 2'd2;
  localparam logic [1:0] COEF_A3 = 2'd3;

  localparam int TONE_Q [CURVE_POINTS] = '{
    -1475, 0, 3113, 6226, 8847, 10977, 12780,
    14090, 14909, 15401, 15729, 15892, 16220, 16876
  };

  // Colors by channel (green, magenta, red), then by component (red, green, blue).
  localparam int HUE_Q [CHAN_COUNT][NUM_COLORS] = '{
    '{4751, 15073, 9994},
    '{15565, 11633, 14909},
    '{15073, 2949, 1278}
  };

  // Catmull-Rom polynomial coefficient k of the segment starting at point seg.
  function automatic logic signed [COEF_W-1:0] spline_coef(input logic [SEG_W-1:0] seg,
                                                           input logic [1:0] k);
    int s;
    int p0;
    int p1;
    int p2;
    int p3;
    int a;
    s = int'(seg);
    if (s < 1) s = 1;
    if (s > CURVE_POINTS - 3) s = CURVE_POINTS - 3;
    p0 = TONE_Q[s-1];
    p1 = TONE_Q[s];
    p2 = TONE_Q[s+1];
    p3 = TONE_Q[s+2];
    case (k)
      COEF_A0: a = 2 * p1;
      COEF_A1: a = p2 - p0;
      COEF_A2: a = 2 * p0 - 5 * p1 + 4 * p2 - p3;
      default: a = -p0 + 3 * p1 - 3 * p2 + p3;
    endcase
    return COEF_W'(a);
  endfunction

endpackage

// ===== rtl/sfc_alpha.sv =====
// Per-channel magnitude, window compare and pipelined restoring divider giving alpha.
module sfc_alpha (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          ce_i,
  input  logic          valid_i,
  input  sfc_pkg::q16_t energy_i,
  input  sfc_pkg::q16_t low_i,
  input  sfc_pkg::q16_t high_i,
  output logic          valid_o,
  output sfc_pkg::q14_t alpha_o
);
  import sfc_pkg::*;

  logic [ENERGY_W:0]        mag;
  logic signed [DIV_W-1:0]  v_d, v_q;
  logic                     v_vld_q;
  logic signed [DIV_W-1:0]  lo_ext, hi_ext, diff_lo, diff_rng;
  alpha_mode_e              mode_d;

  logic [DIV_W-1:0]         rem_q  [DIV_STEPS+1];
  logic [DIV_W-1:0]         den_q  [DIV_STEPS+1];
  logic [DIV_STEPS-1:0]     quo_q  [DIV_STEPS+1];
  alpha_mode_e              mode_q [DIV_STEPS+1];
  logic                     vld_q  [DIV_STEPS+1];
  logic [DIV_W-1:0]         rem_d  [DIV_STEPS];
  logic [DIV_STEPS-1:0]     quo_d  [DIV_STEPS];
  logic [DIV_W-1:0]         shl    [DIV_STEPS];

  always_comb begin
    mag = energy_i[ENERGY_W-1] ? ((ENERGY_W+1)'(0) - {energy_i[ENERGY_W-1], energy_i})
                               : {1'b0, energy_i};
    v_d = $signed({1'b0, mag}) - DIV_W'(ENERGY_ONE);
  end

  always_comb begin
    lo_ext   = {{(DIV_W-ENERGY_W){low_i[ENERGY_W-1]}}, low_i};
    hi_ext   = {{(DIV_W-ENERGY_W){high_i[ENERGY_W-1]}}, high_i};
    diff_lo  = v_q - lo_ext;
    diff_rng = hi_ext - lo_ext;
    if (v_q <= lo_ext) begin
      mode_d = ALPHA_ZERO;
    end else if (v_q >= hi_ext) begin
      mode_d = ALPHA_ONE;
    end else begin
      mode_d = ALPHA_DIV;
    end
  end

  // One quotient bit per stage; in the divide mode the remainder stays below the range.
  always_comb begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      shl[k] = {rem_q[k][DIV_W-2:0], 1'b0};
      if (shl[k] >= den_q[k]) begin
        rem_d[k] = shl[k] - den_q[k];
        quo_d[k] = {quo_q[k][DIV_STEPS-2:0], 1'b1};
      end else begin
        rem_d[k] = shl[k];
        quo_d[k] = {quo_q[k][DIV_STEPS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_vld_q <= 1'b0;
      for (int k = 0; k <= DIV_STEPS; k++) vld_q[k] <= 1'b0;
    end else if (ce_i) begin
      v_vld_q  <= valid_i;
      vld_q[0] <= v_vld_q;
      for (int k = 0; k < DIV_STEPS; k++) vld_q[k+1] <= vld_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      v_q       <= v_d;
      rem_q[0]  <= diff_lo;
      den_q[0]  <= diff_rng;
      quo_q[0]  <= '0;
      mode_q[0] <= mode_d;
      for (int k = 0; k < DIV_STEPS; k++) begin
        rem_q[k+1]  <= rem_d[k];
        den_q[k+1]  <= den_q[k];
        quo_q[k+1]  <= quo_d[k];
        mode_q[k+1] <= mode_q[k];
      end
    end
  end

  always_comb begin
    case (mode_q[DIV_STEPS])
      ALPHA_ZERO: alpha_o = '0;
      ALPHA_ONE:  alpha_o = ALPHA_W'(Q_ONE);
      default:    alpha_o = {1'b0, quo_q[DIV_STEPS]};
    endcase
  end

  assign valid_o = vld_q[DIV_STEPS];

endmodule

// ===== rtl/sfc_curve.sv =====
// Catmull-Rom tone curve evaluated by a three-multiply Horner pipeline.
module sfc_curve (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          ce_i,
  input  logic          valid_i,
  input  sfc_pkg::q14_t alpha_i,
  output logic          valid_o,
  output sfc_pkg::q14_t inten_o
);
  import sfc_pkg::*;

  localparam int U_W    = FRAC_W + SEG_W;
  localparam int ACC1_W = 40;
  localparam int ACC_W  = 64;

  logic [U_W-1:0]          u;
  logic [SEG_W-1:0]        seg0_q, seg1_q, seg2_q;
  logic [FRAC_W-1:0]       t0_q, t1_q, t2_q;
  logic signed [ACC1_W-1:0] acc1_d, acc1_q;
  logic signed [ACC_W-1:0]  acc2_d, acc2_q, acc3_d, acc3_q;
  logic signed [ACC_W-1:0]  r;
  logic [ALPHA_W-1:0]      inten_d, inten_q;
  logic [4:0]              vld_q;

  // u = 1 + 10 * alpha in Q14; the integer part picks the segment.
  assign u = U_W'(Q_ONE) + (U_W'(alpha_i) << 3) + (U_W'(alpha_i) << 1);

  // Operands are widened before each multiply so the products keep every bit.
  always_comb begin
    acc1_d = ACC1_W'(spline_coef(seg0_q, COEF_A3)) * ACC1_W'($signed({1'b0, t0_q}))
           + (ACC1_W'(spline_coef(seg0_q, COEF_A2)) <<< FRAC_W);
    acc2_d = ACC_W'(acc1_q) * ACC_W'($signed({1'b0, t1_q}))
           + (ACC_W'(spline_coef(seg1_q, COEF_A1)) <<< (2 * FRAC_W));
    acc3_d = acc2_q * ACC_W'($signed({1'b0, t2_q}))
           + (ACC_W'(spline_coef(seg2_q, COEF_A0)) <<< (3 * FRAC_W));
    r = acc3_q >>> (3 * FRAC_W + 1);
    if (acc3_q <= 0) begin
      inten_d = '0;
    end else if (r > ACC_W'(Q_ONE)) begin
      inten_d = ALPHA_W'(Q_ONE);
    end else begin
      inten_d = r[ALPHA_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ce_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      seg0_q  <= u[U_W-1:FRAC_W];
      t0_q    <= u[FRAC_W-1:0];
      seg1_q  <= seg0_q;
      t1_q    <= t0_q;
      acc1_q  <= acc1_d;
      seg2_q  <= seg1_q;
      t2_q    <= t1_q;
      acc2_q  <= acc2_d;
      acc3_q  <= acc3_d;
      inten_q <= inten_d;
    end
  end

  assign valid_o = vld_q[4];
  assign inten_o = inten_q;

endmodule

// ===== rtl/spline_false_color_pixel_mapper_unit.sv =====
// Top level of the false-color pixel mapper: register file, channel lanes and color mix.
//
//   channel      | dir | contents
//   s_axis       | in  | tdata: green_energy, magenta_energy, red_energy (32 b each)
//   m_axis       | out | tdata: out_red, out_green, out_blue (8 b each)
//   apb          | cfg | six 32-bit window registers at byte addresses 0..20
//
// One pixel enters per cycle while the output word is not held. Each word passes
// 16 stages for the magnitude, window compare and one-bit-per-stage divider, 5 for
// the spline Horner multiplies and clamp, 2 for color weighting and output scaling.
// The whole pipeline advances together; when the output word is held, every stage
// holds and s_axis_tready_o drops, so no word is lost or repeated.
// Reset clears the valid bits and loads the window registers with 0 and 1.0.
module spline_false_color_pixel_mapper_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // green_energy [31:0], magenta_energy [63:32], red_energy [95:64]
  input  logic [3*32-1:0]           s_axis_tdata_i,
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  // out_red [7:0], out_green [15:8], out_blue [23:16]
  output logic [3*8-1:0]            m_axis_tdata_o,
  input  logic                      psel_i,
  input  logic                      penable_i,
  input  logic                      pwrite_i,
  input  logic [sfc_pkg::ADDR_W-1:0] paddr_i,
  input  logic [31:0]               pwdata_i,
  output logic [31:0]               prdata_o,
  output logic                      pready_o
);
  import sfc_pkg::*;

  localparam logic [2:0] REG_GREEN_LOW    = 3'd0;
  localparam logic [2:0] REG_GREEN_HIGH   = 3'd1;
  localparam logic [2:0] REG_MAGENTA_LOW  = 3'd2;
  localparam logic [2:0] REG_MAGENTA_HIGH = 3'd3;
  localparam logic [2:0] REG_RED_LOW      = 3'd4;
  localparam logic [2:0] REG_RED_HIGH     = 3'd5;

  // Window registers, indexed by channel: green, magenta, red.
  q16_t lo_q [CFG_PAIRS];
  q16_t hi_q [CFG_PAIRS];

  logic [2:0] reg_idx;
  logic       cfg_wr;

  assign pready_o = 1'b1;
  assign reg_idx  = paddr_i[4:2];
  assign cfg_wr   = psel_i && penable_i && pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CFG_PAIRS; c++) begin
        lo_q[c] <= '0;
        hi_q[c] <= ENERGY_W'(ENERGY_ONE);
      end
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_GREEN_LOW:    lo_q[0] <= pwdata_i;
        REG_GREEN_HIGH:   hi_q[0] <= pwdata_i;
        REG_MAGENTA_LOW:  lo_q[1] <= pwdata_i;
        REG_MAGENTA_HIGH: hi_q[1] <= pwdata_i;
        REG_RED_LOW:      lo_q[2] <= pwdata_i;
        REG_RED_HIGH:     hi_q[2] <= pwdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GREEN_LOW:    prdata_o = lo_q[0];
      REG_GREEN_HIGH:   prdata_o = hi_q[0];
      REG_MAGENTA_LOW:  prdata_o = lo_q[1];
      REG_MAGENTA_HIGH: prdata_o = hi_q[1];
      REG_RED_LOW:      prdata_o = lo_q[2];
      REG_RED_HIGH:     prdata_o = hi_q[2];
      default:          prdata_o = '0;
    endcase
  end

  // The pipeline moves whenever the output register is empty or being drained.
  logic ce;
  logic out_vld_q;

  assign ce              = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = ce;

  logic [CHAN_COUNT-1:0] alpha_vld;
  logic [CHAN_COUNT-1:0] lane_vld;
  q14_t                  alpha [CHAN_COUNT];
  q14_t                  inten [CHAN_COUNT];

  for (genvar c = 0; c < CHAN_COUNT; c++) begin : g_lane
    sfc_alpha u_alpha (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ce_i     (ce),
      .valid_i  (s_axis_tvalid_i),
      .energy_i (s_axis_tdata_i[ENERGY_W*c +: ENERGY_W]),
      .low_i    (lo_q[c]),
      .high_i   (hi_q[c]),
      .valid_o  (alpha_vld[c]),
      .alpha_o  (alpha[c])
    );

    sfc_curve u_curve (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ce_i    (ce),
      .valid_i (alpha_vld[c]),
      .alpha_i (alpha[c]),
      .valid_o (lane_vld[c]),
      .inten_o (inten[c])
    );
  end

  // Weight each channel's fixed color by its intensity.
  logic [CONTRIB_W-1:0] contrib_q [CHAN_COUNT][NUM_COLORS];
  logic [2*FRAC_W:0]    prod      [CHAN_COUNT][NUM_COLORS];
  logic                 mix_vld_q;

  always_comb begin
    for (int c = 0; c < CHAN_COUNT; c++) begin
      for (int k = 0; k < NUM_COLORS; k++) begin
        prod[c][k] = (2*FRAC_W+1)'(inten[c]) * (2*FRAC_W+1)'(HUE_Q[c][k]);
      end
    end
  end

  // Sum the contributions and scale to 0..255 with saturation.
  logic [SUM_W-1:0]   sum    [NUM_COLORS];
  logic [SUM_W+7:0]   scaled [NUM_COLORS];
  logic [PIX_W-1:0]   pix_d  [NUM_COLORS];
  logic [PIX_W-1:0]   pix_q  [NUM_COLORS];

  always_comb begin
    for (int k = 0; k < NUM_COLORS; k++) begin
      sum[k] = '0;
      for (int c = 0; c < CHAN_COUNT; c++) begin
        sum[k] = sum[k] + SUM_W'(contrib_q[c][k]);
      end
      scaled[k] = {sum[k], 8'b0} - (SUM_W+8)'(sum[k]);
      if (sum[k] == '0) begin
        pix_d[k] = '0;
      end else if (sum[k] >= SUM_W'(Q_ONE)) begin
        pix_d[k] = '1;
      end else begin
        pix_d[k] = scaled[k][FRAC_W +: PIX_W];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mix_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (ce) begin
      mix_vld_q <= &lane_vld;
      out_vld_q <= mix_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int c = 0; c < CHAN_COUNT; c++) begin
        for (int k = 0; k < NUM_COLORS; k++) begin
          contrib_q[c][k] <= prod[c][k][FRAC_W +: CONTRIB_W];
        end
      end
      for (int k = 0; k < NUM_COLORS; k++) pix_q[k] <= pix_d[k];
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {pix_q[2], pix_q[1], pix_q[0]};

  // All lanes run in lock step, so their valid bits always agree.
  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lane_vld == '0) || (&lane_vld))
    else $error("channel lanes out of step");

  // The clamped intensity of lane 0 (green) never exceeds one.
  a_inten_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane_vld[0] |-> (inten[0] <= ALPHA_W'(Q_ONE)))
    else $error("intensity above one");

  // A full-scale red sum saturates the red output.
  a_red_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ce && mix_vld_q && (sum[0] >= SUM_W'(Q_ONE))) |=> (m_axis_tdata_o[7:0] == 8'hFF))
    else $error("red output not saturated");

endmodule
